// File: rtl/core/bps_pkg.sv
// bps_pkg: shared constants, widths and sequencer state type for the bar
// peak spreading smoother; no dependencies
package bps_pkg;

  // frame size bound and derived widths
  localparam int MAX_BARS = 64;
  localparam int CNT_W    = $clog2(MAX_BARS + 1);
  localparam int IDX_W    = $clog2(MAX_BARS);

  // field widths
  localparam int BAR_W    = 24;
  localparam int WGT_W    = 17;
  localparam int PROD_W   = BAR_W + WGT_W;
  localparam int CFG_IDX_W = 1;

  // 1.0 in unsigned q1.16
  localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);

  // reset values of the configuration registers
  localparam logic [WGT_W-1:0] DECAY_RST = WGT_W'(43691);
  localparam logic [BAR_W-1:0] MIN_RST   = BAR_W'(256);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN   = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_LOAD,
    S_WB,
    S_SP_HEAD,
    S_SP_CHK,
    S_SP_RUN,
    S_SP_D1,
    S_SP_D2,
    S_EM_RD,
    S_EM_OUT
  } bps_state_t;

endpackage

// File: rtl/core/bps_mul.sv
// bps_mul: shared registered multiplier, 24 by 17 bits unsigned
// depends on bps_pkg
module bps_mul
  import bps_pkg::*;
(
  input  logic              clk,
  input  logic [BAR_W-1:0]  mul_a,
  input  logic [WGT_W-1:0]  mul_b,
  output logic [PROD_W-1:0] prod_r
);

  logic [PROD_W-1:0] prod_nxt;

  // full product, registered
  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: rtl/core/bar_peak_spread_smoother.sv
// a frame of n bars loads at one bar per cycle; after the last bar the weights
// are built one per cycle, each bar 1..n-1 is either raised to the minimum (below
// minimum) or spread over all other bars through the shared multiplier, and
// emission then runs at one bar per cycle while out_tready is high
// reset: rst_n synchronous, active low; clears the sequencer, bar count and
// configuration; the bar and weight memories are not cleared
module bar_peak_spread_smoother
  import bps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BAR_W-1:0]     cfg_data,
  // input bars
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BAR_W-1:0]     in_tdata,   // [23:0] bar_in
  input  logic                 in_tlast,   // frame_end
  // smoothed bars
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BAR_W-1:0]     out_tdata,  // [23:0] bar_out
  output logic                 out_tlast   // final_bar
);

  // configuration registers
  logic [WGT_W-1:0] decay_r;
  logic [BAR_W-1:0] min_r;
  logic [WGT_W-1:0] r_sat;

  // sequencer state and counters
  bps_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] wk_r, wk_nxt;
  logic [BAR_W-1:0] b_r, b_nxt;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] n_load;
  logic             cnt_full;
  logic             in_acc;
  logic             advance_i;
  logic [IDX_W-1:0] bar_gap;

  // memories
  logic [BAR_W-1:0] bar_mem [MAX_BARS];
  logic [WGT_W-1:0] w_mem   [MAX_BARS];
  logic             bar_we, bar_re, w_we, w_re;
  logic [IDX_W-1:0] bar_waddr, bar_raddr, w_waddr;
  logic [BAR_W-1:0] bar_wdata, bar_rdata_r;
  logic [WGT_W-1:0] w_wdata, w_rdata_r;

  // spreading pipeline
  logic              issue;
  logic              v1_r, v2_r;
  logic [IDX_W-1:0]  j1_r, j2_r;
  logic [BAR_W-1:0]  bar_d_r;
  logic [BAR_W-1:0]  mul_a;
  logic [WGT_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod_r;
  logic [BAR_W-1:0]  spread_v;

  // shared multiplier
  bps_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RST;
      min_r   <= MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DECAY: decay_r <= cfg_data[WGT_W-1:0];
        REG_MIN:   min_r   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // reciprocal above one acts as one
  assign r_sat = (decay_r > ONE_Q16) ? ONE_Q16 : decay_r;

  // handshake and derived values
  assign in_tready  = (state_r == S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign cnt_full   = (cnt_r == CNT_W'(MAX_BARS));
  assign n_load     = cnt_full ? cnt_r : cnt_r + CNT_W'(1);
  assign last_idx   = cnt_r - CNT_W'(1);
  assign bar_gap    = (i_r > j_r) ? (i_r - j_r) : (j_r - i_r);
  assign spread_v   = prod_r[BAR_W+15:16];
  assign out_tvalid = (state_r == S_EM_OUT);
  assign out_tdata  = bar_rdata_r;
  assign out_tlast  = ({1'b0, j_r} == last_idx);

  // state register and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    wk_r    <= wk_nxt;
    b_r     <= b_nxt;
    j1_r    <= j_r;
    j2_r    <= j1_r;
    bar_d_r <= bar_rdata_r;
  end

  // bar memory
  always_ff @(posedge clk) begin
    if (bar_we) begin
      bar_mem[bar_waddr] <= bar_wdata;
    end
    if (bar_re) begin
      bar_rdata_r <= bar_mem[bar_raddr];
    end
  end

  // weight memory
  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= w_wdata;
    end
    if (w_re) begin
      w_rdata_r <= w_mem[bar_gap];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    wk_nxt    = wk_r;
    b_nxt     = b_r;
    advance_i = 1'b0;
    issue     = 1'b0;
    bar_re    = 1'b0;
    bar_raddr = j_r;
    w_re      = 1'b0;
    w_we      = 1'b0;
    w_waddr   = wk_r;
    w_wdata   = prod_r[WGT_W+15:16];
    mul_a     = b_r;
    mul_b     = w_rdata_r;
    // spreading write-back, raise bar j when the spread value is larger
    bar_we    = v2_r && (bar_d_r < spread_v);
    bar_waddr = j2_r;
    bar_wdata = spread_v;

    case (state_r)
      S_LOAD: begin
        // multiplier primed with 1.0 * r so the first weight is ready
        mul_a = BAR_W'(ONE_Q16);
        mul_b = r_sat;
        if (in_acc) begin
          if (!cnt_full) begin
            bar_we    = 1'b1;
            bar_waddr = cnt_r[IDX_W-1:0];
            bar_wdata = in_tdata;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          if (in_tlast) begin
            i_nxt  = IDX_W'(1);
            j_nxt  = '0;
            wk_nxt = IDX_W'(1);
            if (n_load == CNT_W'(1)) begin
              state_nxt = S_EM_RD;
            end else begin
              state_nxt = S_WB;
            end
          end
        end
      end
      S_WB: begin
        // one decay weight per cycle, fed back through the multiplier
        mul_a = BAR_W'(prod_r[WGT_W+15:16]);
        mul_b = r_sat;
        w_we  = 1'b1;
        if ({1'b0, wk_r} == last_idx) begin
          state_nxt = S_SP_HEAD;
        end else begin
          wk_nxt = wk_r + IDX_W'(1);
        end
      end
      S_SP_HEAD: begin
        bar_re    = 1'b1;
        bar_raddr = i_r;
        state_nxt = S_SP_CHK;
      end
      S_SP_CHK: begin
        if (bar_rdata_r < min_r) begin
          bar_we    = 1'b1;
          bar_waddr = i_r;
          bar_wdata = min_r;
          advance_i = 1'b1;
        end else begin
          b_nxt     = bar_rdata_r;
          j_nxt     = '0;
          state_nxt = S_SP_RUN;
        end
      end
      S_SP_RUN: begin
        // one target bar per cycle into the pipeline
        bar_re = 1'b1;
        w_re   = 1'b1;
        issue  = (j_r != i_r);
        if ({1'b0, j_r} == last_idx) begin
          state_nxt = S_SP_D1;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_SP_D1: begin
        state_nxt = S_SP_D2;
      end
      S_SP_D2: begin
        advance_i = 1'b1;
      end
      S_EM_RD: begin
        bar_re    = 1'b1;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_tready) begin
          if (out_tlast) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            bar_re    = 1'b1;
            bar_raddr = j_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // next visited bar, or emission after the last one
    if (advance_i) begin
      if ({1'b0, i_r} == last_idx) begin
        j_nxt     = '0;
        state_nxt = S_EM_RD;
      end else begin
        i_nxt     = i_r + IDX_W'(1);
        state_nxt = S_SP_HEAD;
      end
    end
  end

  // input and output never open at once
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while results pending");

  // a frame end closes the input
  a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still open after frame end");

  // last result reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && cnt_r == '0))
    else $error("input not reopened after last result");

  // bar count within bound
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BARS))
    else $error("bar count beyond bound");

endmodule
